@@ rtl/mbt_pkg.sv @@
// Shared types, constants and helpers for the markup byte tokenizer.
`timescale 1ns / 1ps

package mbt_pkg;

  localparam int POS_BITS   = 16;
  localparam int OFF_W      = 16;
  localparam int LVL_W      = 6;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [LVL_W-1:0] MAX_HEADER = LVL_W'(63);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  typedef logic [POS_BITS-1:0] pos_t;

  typedef enum logic [2:0] {
    KIND_TEXT   = 3'd0,
    KIND_HEADER = 3'd1,
    KIND_EM1    = 3'd2,
    KIND_EM2    = 3'd3,
    KIND_NL     = 3'd4,
    KIND_END    = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [OFF_W-1:0]  start_off;
    logic [OFF_W-1:0]  end_off;
    logic [LVL_W-1:0]  level;
    logic              last;
  } tok_t;

  function automatic logic [OFF_W-1:0] to_off(input pos_t p);
    logic [POS_BITS+OFF_W-1:0] ext;
    ext = {{OFF_W{1'b0}}, p};
    return ext[OFF_W-1:0];
  endfunction

  function automatic logic is_special(input logic [7:0] b);
    return (b == CH_HASH) || (b == CH_STAR) || (b == CH_NL) || (b == CH_LBRK) ||
           (b == CH_RBRK) || (b == CH_LPAR) || (b == CH_RPAR) || (b == CH_UNDER);
  endfunction

  function automatic tok_t mk_tok(input kind_t k, input pos_t s, input pos_t e,
                                  input logic [LVL_W-1:0] lvl);
    tok_t t;
    t.kind      = k;
    t.start_off = to_off(s);
    t.end_off   = to_off(e);
    t.level     = lvl;
    t.last      = 1'b0;
    return t;
  endfunction

endpackage

@@ rtl/mbt_step.sv @@
// Per-byte run tracking and token generation for the markup byte tokenizer.
`timescale 1ns / 1ps

module mbt_step (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step_go,
  input  logic [7:0]                byte_i,
  output mbt_pkg::tok_t             tok0,
  output mbt_pkg::tok_t             tok1,
  output logic [1:0]                tok_cnt
);

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_TEXT = 2'd1,
    MODE_HASH = 2'd2,
    MODE_STAR = 2'd3
  } mode_t;

  mode_t                          mode_r, mode_nxt, eff_mode;
  mbt_pkg::pos_t                  pos_r, pos_nxt;
  mbt_pkg::pos_t                  start_r, start_nxt;
  logic [mbt_pkg::LVL_W-1:0]      hash_r, hash_nxt;
  mbt_pkg::pos_t                  pos_p1, pos_m1;
  logic                           has_close, has_tail, pair_done, is_nul, is_spec;
  mbt_pkg::tok_t                  close_tok, tail_tok;

  assign pos_p1  = pos_r + 1'b1;
  assign pos_m1  = pos_r - 1'b1;
  assign is_nul  = (byte_i == mbt_pkg::CH_NUL);
  assign is_spec = mbt_pkg::is_special(byte_i);

  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    start_nxt = start_r;
    hash_nxt  = hash_r;
    eff_mode  = mode_r;
    has_close = 1'b0;
    has_tail  = 1'b0;
    pair_done = 1'b0;
    close_tok = mbt_pkg::mk_tok(mbt_pkg::KIND_TEXT, start_r, pos_m1, '0);
    tail_tok  = mbt_pkg::mk_tok(mbt_pkg::KIND_END, pos_r, pos_r, '0);

    unique case (mode_r)
      MODE_TEXT: begin
        if (is_nul || is_spec) begin
          has_close = 1'b1;
          eff_mode  = MODE_IDLE;
        end
      end
      MODE_HASH: begin
        if (byte_i != mbt_pkg::CH_HASH) begin
          has_close = 1'b1;
          close_tok = mbt_pkg::mk_tok(mbt_pkg::KIND_HEADER, start_r, pos_m1, hash_r);
          eff_mode  = MODE_IDLE;
        end
      end
      MODE_STAR: begin
        has_close = 1'b1;
        eff_mode  = MODE_IDLE;
        if (byte_i == mbt_pkg::CH_STAR) begin
          pair_done = 1'b1;
          close_tok = mbt_pkg::mk_tok(mbt_pkg::KIND_EM2, start_r, pos_r, '0);
        end else begin
          close_tok = mbt_pkg::mk_tok(mbt_pkg::KIND_EM1, start_r, start_r, '0);
        end
      end
      MODE_IDLE: ;
      default: ;
    endcase

    mode_nxt = eff_mode;

    if (pair_done) begin
      pos_nxt = pos_p1;
    end else if (is_nul) begin
      has_tail  = 1'b1;
      mode_nxt  = MODE_IDLE;
      pos_nxt   = '0;
      start_nxt = '0;
      hash_nxt  = '0;
    end else begin
      pos_nxt = pos_p1;
      unique case (eff_mode)
        MODE_HASH: begin
          if (hash_r < mbt_pkg::MAX_HEADER) begin
            hash_nxt = hash_r + 1'b1;
          end
        end
        MODE_IDLE: begin
          start_nxt = pos_r;
          if (byte_i == mbt_pkg::CH_HASH) begin
            mode_nxt = MODE_HASH;
            hash_nxt = mbt_pkg::LVL_W'(1);
          end else if (byte_i == mbt_pkg::CH_STAR) begin
            mode_nxt = MODE_STAR;
          end else if (byte_i == mbt_pkg::CH_NL) begin
            start_nxt = start_r;
            has_tail  = 1'b1;
            tail_tok  = mbt_pkg::mk_tok(mbt_pkg::KIND_NL, pos_r, pos_r, '0);
          end else begin
            mode_nxt = MODE_TEXT;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    tok0    = close_tok;
    tok1    = tail_tok;
    tok_cnt = 2'd0;
    if (has_close && has_tail) begin
      tok1.last = 1'b1;
      tok_cnt   = 2'd2;
    end else if (has_close) begin
      tok0.last = 1'b1;
      tok_cnt   = 2'd1;
    end else if (has_tail) begin
      tok0      = tail_tok;
      tok0.last = 1'b1;
      tok_cnt   = 2'd1;
    end
    if (!step_go) begin
      tok_cnt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      pos_r   <= '0;
      start_r <= '0;
      hash_r  <= '0;
    end else if (step_go) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      hash_r  <= hash_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_hash_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_HASH) |-> (hash_r != '0))
    else $error("hash run open with zero count");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_cnt == 2'd2) |-> (!tok0.last && tok1.last))
    else $error("two-token beat with wrong last flags");

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (step_go && is_nul && !pair_done) |=> (pos_r == '0 && mode_r == MODE_IDLE))
    else $error("end of document did not clear position");
`endif

endmodule

@@ rtl/mbt_fifo.sv @@
// Token queue for the markup byte tokenizer: two writes, one read per cycle.
`timescale 1ns / 1ps

module mbt_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    push_cnt,
  input  mbt_pkg::tok_t push0,
  input  mbt_pkg::tok_t push1,
  output logic          room,
  output logic          out_valid,
  input  logic          out_ready,
  output mbt_pkg::tok_t out_tok
);

  mbt_pkg::tok_t                  mem [mbt_pkg::FIFO_DEPTH];
  logic [mbt_pkg::FIFO_AW-1:0]    wr_r, rd_r, wr_p1;
  logic [mbt_pkg::FIFO_CW-1:0]    cnt_r, cnt_nxt;
  logic                           pop;

  assign out_valid = (cnt_r != '0);
  assign out_tok   = mem[rd_r];
  assign pop       = out_valid && out_ready;
  assign room      = (cnt_r <= mbt_pkg::FIFO_CW'(mbt_pkg::FIFO_DEPTH - 2));
  assign wr_p1     = wr_r + 1'b1;
  assign cnt_nxt   = cnt_r + mbt_pkg::FIFO_CW'(push_cnt) - mbt_pkg::FIFO_CW'(pop);

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_p1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + mbt_pkg::FIFO_AW'(push_cnt);
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= mbt_pkg::FIFO_CW'(mbt_pkg::FIFO_DEPTH))
    else $error("token queue overflow");

  a_push_with_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push_cnt != 2'd0) |-> room)
    else $error("push into full token queue");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == mbt_pkg::FIFO_CW'(1) && pop && push_cnt == 2'd0) |=> !out_valid)
    else $error("queue not empty after last beat left");
`endif

endmodule

@@ rtl/markup_byte_tokenizer.sv @@
// A byte's tokens pass through the input register, then the token queue, before they appear.
// Throughput: one byte per cycle while the token queue has room and each byte
// yields at most one token; a two-token byte takes two beats through the queue.
// Output beats: at most one per cycle, set by the single read port of the queue.
// Reset (rst_n low, synchronous): idle mode, position, run start and hash count
// cleared, input register and token queue emptied.
`timescale 1ns / 1ps

module markup_byte_tokenizer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_token_kind,
  output logic [mbt_pkg::OFF_W-1:0]     out_start_offset,
  output logic [mbt_pkg::OFF_W-1:0]     out_end_offset,
  output logic [mbt_pkg::LVL_W-1:0]     out_hash_depth,
  output logic                          out_last_of_run
);

  logic          in_vld_r;
  logic [7:0]    in_byte_r;
  logic          room, step_go;
  logic [1:0]    tok_cnt;
  mbt_pkg::tok_t tok0, tok1, out_tok;

  assign step_go  = in_vld_r && room;
  assign in_ready = !in_vld_r || room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_byte;
    end
  end

  mbt_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_go (step_go),
    .byte_i  (in_byte_r),
    .tok0    (tok0),
    .tok1    (tok1),
    .tok_cnt (tok_cnt)
  );

  mbt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (tok_cnt),
    .push0     (tok0),
    .push1     (tok1),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_tok   (out_tok)
  );

  assign out_token_kind   = out_tok.kind;
  assign out_start_offset = out_tok.start_off;
  assign out_end_offset   = out_tok.end_off;
  assign out_hash_depth   = out_tok.level;
  assign out_last_of_run  = out_tok.last;

endmodule

@@ sim/markup_byte_tokenizer_test.sv @@
// Self-checking testbench for the markup byte tokenizer: token stream against a built-in scanner.
`timescale 1ns / 1ps

module markup_byte_tokenizer_test;

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_TEXT,
    SCAN_HASH,
    SCAN_STAR
  } scan_mode_t;

  localparam int LONG_HOLD  = 200;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [7:0]                    in_byte = 8'h00;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [2:0]                    out_token_kind;
  logic [mbt_pkg::OFF_W-1:0]     out_start_offset;
  logic [mbt_pkg::OFF_W-1:0]     out_end_offset;
  logic [mbt_pkg::LVL_W-1:0]     out_hash_depth;
  logic                          out_last_of_run;

  scan_mode_t                    scan_mode = SCAN_IDLE;
  mbt_pkg::pos_t                 scan_start = '0;
  mbt_pkg::pos_t                 scan_pos = '0;
  logic [mbt_pkg::LVL_W-1:0]     hash_len = '0;
  mbt_pkg::tok_t                 pending_tokens[$];

  int                   mismatches = 0;
  int                   bytes_sent = 0;
  int                   tokens_checked = 0;
  int                   docs_closed = 0;
  bit                   tx_burst = 1'b0;
  bit                   rx_burst = 1'b0;
  int                   hold_req = 0;
  int                   hold_done = 0;

  markup_byte_tokenizer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_start_offset (out_start_offset),
    .out_end_offset   (out_end_offset),
    .out_hash_depth   (out_hash_depth),
    .out_last_of_run  (out_last_of_run)
  );

  always #6 clk = ~clk;

  function automatic bit ends_text(input logic [7:0] b);
    case (b)
      mbt_pkg::CH_HASH, mbt_pkg::CH_STAR, mbt_pkg::CH_NL, mbt_pkg::CH_LBRK,
      mbt_pkg::CH_RBRK, mbt_pkg::CH_LPAR, mbt_pkg::CH_RPAR, mbt_pkg::CH_UNDER: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic mbt_pkg::tok_t make_token(input mbt_pkg::kind_t k,
                                               input mbt_pkg::pos_t s,
                                               input mbt_pkg::pos_t e,
                                               input logic [mbt_pkg::LVL_W-1:0] lvl);
    mbt_pkg::tok_t t;
    t.kind      = k;
    t.start_off = s;
    t.end_off   = e;
    t.level     = lvl;
    t.last      = 1'b0;
    return t;
  endfunction

  task automatic predict_tokens(input logic [7:0] b);
    mbt_pkg::tok_t toks[$];
    mbt_pkg::pos_t prev;
    bit            done;
    prev = scan_pos - 1'b1;
    done = 1'b0;
    case (scan_mode)
      SCAN_TEXT: begin
        if (b == mbt_pkg::CH_NUL || ends_text(b)) begin
          toks.push_back(make_token(mbt_pkg::KIND_TEXT, scan_start, prev, '0));
          scan_mode = SCAN_IDLE;
        end
      end
      SCAN_HASH: begin
        if (b != mbt_pkg::CH_HASH) begin
          toks.push_back(make_token(mbt_pkg::KIND_HEADER, scan_start, prev, hash_len));
          scan_mode = SCAN_IDLE;
        end
      end
      SCAN_STAR: begin
        scan_mode = SCAN_IDLE;
        if (b == mbt_pkg::CH_STAR) begin
          toks.push_back(make_token(mbt_pkg::KIND_EM2, scan_start, scan_pos, '0));
          scan_pos = scan_pos + 1'b1;
          done = 1'b1;
        end else begin
          toks.push_back(make_token(mbt_pkg::KIND_EM1, scan_start, scan_start, '0));
        end
      end
      default: ;
    endcase
    if (!done && b == mbt_pkg::CH_NUL) begin
      toks.push_back(make_token(mbt_pkg::KIND_END, scan_pos, scan_pos, '0));
      scan_mode  = SCAN_IDLE;
      scan_start = '0;
      scan_pos   = '0;
      hash_len   = '0;
      docs_closed++;
      done = 1'b1;
    end
    if (!done) begin
      if (scan_mode == SCAN_HASH) begin
        if (hash_len < mbt_pkg::MAX_HEADER) hash_len = hash_len + 1'b1;
      end else if (scan_mode == SCAN_IDLE) begin
        if (b == mbt_pkg::CH_HASH) begin
          scan_mode  = SCAN_HASH;
          scan_start = scan_pos;
          hash_len   = mbt_pkg::LVL_W'(1);
        end else if (b == mbt_pkg::CH_STAR) begin
          scan_mode  = SCAN_STAR;
          scan_start = scan_pos;
        end else if (b == mbt_pkg::CH_NL) begin
          toks.push_back(make_token(mbt_pkg::KIND_NL, scan_pos, scan_pos, '0));
        end else begin
          scan_mode  = SCAN_TEXT;
          scan_start = scan_pos;
        end
      end
      scan_pos = scan_pos + 1'b1;
    end
    if (toks.size() > 0) toks[toks.size()-1].last = 1'b1;
    foreach (toks[i]) pending_tokens.push_back(toks[i]);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns token %0d: %s got %0d want %0d", $time, tokens_checked, what, got, want);
    mismatches++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    predict_tokens(b);
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
    bytes_sent++;
  endtask

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return 8'($urandom_range(8'h61, 8'h7A));
    if (r < 37) return mbt_pkg::CH_HASH;
    if (r < 52) return mbt_pkg::CH_STAR;
    if (r < 62) return mbt_pkg::CH_NL;
    if (r < 72) begin
      case ($urandom_range(0, 4))
        0: return mbt_pkg::CH_LBRK;
        1: return mbt_pkg::CH_RBRK;
        2: return mbt_pkg::CH_LPAR;
        3: return mbt_pkg::CH_RPAR;
        default: return mbt_pkg::CH_UNDER;
      endcase
    end
    if (r < 76) return mbt_pkg::CH_NUL;
    return 8'($urandom_range(0, 255));
  endfunction

  always @(posedge clk) begin
    mbt_pkg::tok_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_tokens.size() == 0) begin
        report_mismatch("unexpected beat, kind", int'(out_token_kind), -1);
      end else begin
        want = pending_tokens.pop_front();
        if (out_token_kind !== want.kind)
          report_mismatch("token_kind", int'(out_token_kind), int'(want.kind));
        if (out_start_offset !== want.start_off)
          report_mismatch("start_offset", int'(out_start_offset), int'(want.start_off));
        if (out_end_offset !== want.end_off)
          report_mismatch("end_offset", int'(out_end_offset), int'(want.end_off));
        if (out_hash_depth !== want.level)
          report_mismatch("hash_depth", int'(out_hash_depth), int'(want.level));
        if (out_last_of_run !== want.last)
          report_mismatch("last_of_run", int'(out_last_of_run), int'(want.last));
      end
      tokens_checked++;
    end
  end

  initial begin : token_sink
    int w;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_done != hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = hold_req;
      end
      w = rx_burst ? 0 : $urandom_range(0, 7);
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  task automatic test_directed_tokens();
    logic [7:0] seq[$];
    seq = '{mbt_pkg::CH_NUL, mbt_pkg::CH_HASH, mbt_pkg::CH_HASH, 8'h61,
            mbt_pkg::CH_STAR, mbt_pkg::CH_STAR, mbt_pkg::CH_STAR, mbt_pkg::CH_NL,
            mbt_pkg::CH_LBRK, mbt_pkg::CH_RBRK, mbt_pkg::CH_UNDER, mbt_pkg::CH_LPAR,
            mbt_pkg::CH_RPAR, 8'hFF, 8'h01, mbt_pkg::CH_HASH,
            mbt_pkg::CH_NUL, mbt_pkg::CH_STAR, mbt_pkg::CH_NUL, mbt_pkg::CH_NL,
            mbt_pkg::CH_NUL};
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic test_long_headers();
    int lens[5];
    logic [7:0] stop;
    lens = '{5, 62, 63, 64, 70};
    foreach (lens[i]) begin
      repeat (lens[i]) send_byte(mbt_pkg::CH_HASH);
      case (i % 3)
        0: stop = 8'h78;
        1: stop = mbt_pkg::CH_NL;
        default: stop = mbt_pkg::CH_NUL;
      endcase
      send_byte(stop);
      if (stop != mbt_pkg::CH_NUL) send_byte(mbt_pkg::CH_NUL);
    end
  endtask

  task automatic test_backpressure();
    logic [7:0] b;
    hold_req++;
    tx_burst = 1'b1;
    repeat (48) begin
      case ($urandom_range(0, 3))
        0: b = mbt_pkg::CH_NL;
        1: b = mbt_pkg::CH_STAR;
        2: b = 8'h61;
        default: b = mbt_pkg::CH_RBRK;
      endcase
      send_byte(b);
    end
    send_byte(mbt_pkg::CH_NUL);
    tx_burst = 1'b0;
  endtask

  task automatic test_random_documents();
    for (int i = 0; i < 1200; i++) begin
      if (i % 100 == 0) begin
        tx_burst = ($urandom_range(0, 3) == 0);
        rx_burst = ($urandom_range(0, 3) == 0);
      end
      send_byte(pick_byte());
    end
    send_byte(mbt_pkg::CH_NUL);
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_tokens();
    test_long_headers();
    test_backpressure();
    test_random_documents();
    in_valid <= 1'b0;
    wait (pending_tokens.size() == 0);
    repeat (8) @(posedge clk);
    $display("Sent %0d bytes in %0d documents, checked %0d tokens, %0d mismatches.",
             bytes_sent, docs_closed, tokens_checked, mismatches);
    $display("Covered directed kinds, saturated headers, output stall, random docs.");
    if (mismatches == 0) begin
      $display("markup_byte_tokenizer verification clean");
    end else begin
      $display("markup_byte_tokenizer verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d tokens still pending.", pending_tokens.size());
    $display("markup_byte_tokenizer verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/mbt_pkg.sv
rtl/mbt_step.sv
rtl/mbt_fifo.sv
rtl/markup_byte_tokenizer.sv
sim/markup_byte_tokenizer_test.sv
